[src/svsm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package svsm_pkg;

  // Voice slots and sample store size. The store size must be a power of two,
  // so that store addresses wrap by dropping the upper bits.
  localparam int VOICES     = 16;
  localparam int WAVE_WORDS = 65536;

  localparam int VW    = $clog2(VOICES);
  localparam int AW    = $clog2(WAVE_WORDS);
  localparam int CNT_W = $clog2(2 * VOICES + 2);

  localparam logic [CNT_W-1:0] CNT_SPAN = CNT_W'(2 * VOICES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(2 * VOICES + 1);

  // Word times gain: 16-bit word, 17-bit gain, 33-bit product, Q2.14 scale.
  localparam int GAIN_W = 17;
  localparam int PROD_W = 33;
  localparam int FRAC_W = 14;
  localparam int TERM_W = PROD_W - FRAC_W;
  localparam int ACC_W  = TERM_W + VW;

  localparam logic signed [GAIN_W-1:0] GAIN_ONE = GAIN_W'(16384);

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_VOICE = 2'd1,
    MODE_WORD  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STAT_SAMPLE     = 2'd0,
    STAT_VOICE_OK   = 2'd1,
    STAT_VOICE_FULL = 2'd2,
    STAT_WORD_OK    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic          start_voice;
    logic          write_word;
    logic          tick_begin;
    logic          eval;
    logic          mul_l;
    logic          mul_r;
    logic          tick_end;
    logic [VW-1:0] slot;
  } svsm_cmd_t;

endpackage

`default_nettype wire

[src/stereo_voice_sample_mixer.sv]
// Channel   Ports                                         Handshake
// input     in_mode, in_voice_*, in_word_*                start high while busy low
// result    out_left_out, out_right_out, out_status       out_valid high for one cycle
//
// A voice start or a word write gives its result beat in the cycle after acceptance,
// and busy stays low, so such items can be taken every cycle.
// A tick walks all VOICES slots through one shared multiplier, two products per
// slot, and gives its beat once the mix pass and the done state are through.
// Synchronous active-low reset frees all slots and zeros the sample clock; the
// sample store is not cleared. The receiver cannot stall the result beat.
`timescale 1ns / 1ps
`default_nettype none

module stereo_voice_sample_mixer
  import svsm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic        [1:0]  in_mode,
  input  wire logic        [31:0] in_voice_onset,
  input  wire logic        [16:0] in_voice_length,
  input  wire logic        [15:0] in_voice_start,
  input  wire logic signed [15:0] in_voice_pan,
  input  wire logic        [15:0] in_word_address,
  input  wire logic signed [15:0] in_word_value,
  output logic                    out_valid,
  output logic signed      [15:0] out_left_out,
  output logic signed      [15:0] out_right_out,
  output logic             [1:0]  out_status
);

  svsm_cmd_t cmd;

  svsm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .busy    (busy),
    .cmd     (cmd)
  );

  svsm_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_voice_onset  (in_voice_onset),
    .in_voice_length (in_voice_length),
    .in_voice_start  (in_voice_start),
    .in_voice_pan    (in_voice_pan),
    .in_word_address (in_word_address),
    .in_word_value   (in_word_value),
    .out_valid       (out_valid),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire

[src/svsm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module svsm_ctrl
  import svsm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_mode,
  output logic            busy,
  output svsm_cmd_t       cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // During the mix pass even counts look up a slot and odd counts multiply
  // for the left side; the right side multiply of a slot overlaps the lookup
  // of the next one.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    busy      = (state_r != ST_IDLE);
    cmd       = '0;
    cmd.slot  = cnt_r[VW:1];
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_mode)
            MODE_VOICE: cmd.start_voice = 1'b1;
            MODE_WORD:  cmd.write_word  = 1'b1;
            default: begin
              cmd.tick_begin = 1'b1;
              cnt_nxt        = '0;
              state_nxt      = ST_MIX;
            end
          endcase
        end
      end
      ST_MIX: begin
        cmd.eval  = !cnt_r[0] && (cnt_r < CNT_SPAN);
        cmd.mul_l = cnt_r[0] && (cnt_r < CNT_SPAN);
        cmd.mul_r = !cnt_r[0] && (cnt_r != '0) && (cnt_r <= CNT_SPAN);
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.tick_end = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[src/svsm_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module svsm_datapath
  import svsm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire svsm_cmd_t          cmd,
  input  wire logic        [31:0] in_voice_onset,
  input  wire logic        [16:0] in_voice_length,
  input  wire logic        [15:0] in_voice_start,
  input  wire logic signed [15:0] in_voice_pan,
  input  wire logic        [15:0] in_word_address,
  input  wire logic signed [15:0] in_word_value,
  output logic                    out_valid,
  output logic signed      [15:0] out_left_out,
  output logic signed      [15:0] out_right_out,
  output logic             [1:0]  out_status
);

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [15:0] r;
    if (v > ACC_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -ACC_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Voice slots.
  logic        [VOICES-1:0] slot_busy_r;
  logic        [VOICES-1:0] expire_r;
  logic        [31:0]       onset_r  [VOICES];
  logic        [16:0]       length_r [VOICES];
  logic        [15:0]       vstart_r [VOICES];
  logic signed [15:0]       pan_r    [VOICES];
  logic        [31:0]       clock_r;

  logic signed [15:0] wave_mem [WAVE_WORDS];
  logic signed [15:0] word_r;

  logic                     act_r;
  logic signed [GAIN_W-1:0] gl_r;
  logic signed [GAIN_W-1:0] gr_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r;
  logic                     prod_left_r;
  logic                     prod_act_r;
  logic signed [ACC_W-1:0]  acc_l_r;
  logic signed [ACC_W-1:0]  acc_r_r;

  logic                      out_valid_r;
  logic signed [15:0]        out_left_r;
  logic signed [15:0]        out_right_r;
  logic        [1:0]         out_status_r;

  // Lowest free slot.
  logic          free_any;
  logic [VW-1:0] free_idx;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!slot_busy_r[i]) begin
        free_any = 1'b1;
        free_idx = VW'(i);
      end
    end
  end

  // Slot lookup: window test, store address and end-of-voice test.
  logic [31:0]              now;
  logic [31:0]              now_inc;
  logic [32:0]              win_end;
  logic [31:0]              ofs;
  logic                     act;
  logic                     expire;
  logic [AW-1:0]            rd_addr;
  logic signed [GAIN_W-1:0] pan_ext;

  always_comb begin
    now     = clock_r;
    now_inc = clock_r + 32'd1;
    win_end = {1'b0, onset_r[cmd.slot]} + {16'd0, length_r[cmd.slot]};
    ofs     = now - onset_r[cmd.slot];
    act     = slot_busy_r[cmd.slot] && (now >= onset_r[cmd.slot]) &&
              ({1'b0, now} < win_end);
    expire  = {1'b0, now_inc} > win_end;
    rd_addr = vstart_r[cmd.slot][AW-1:0] + ofs[AW-1:0];
    pan_ext = GAIN_W'(pan_r[cmd.slot]);
  end

  always_ff @(posedge clk) begin
    if (cmd.write_word) begin
      wave_mem[in_word_address[AW-1:0]] <= in_word_value;
    end
    if (cmd.eval) begin
      word_r <= wave_mem[rd_addr];
    end
  end

  // One shared multiplier, left gain then right gain per slot.
  logic signed [GAIN_W-1:0] gain_sel;
  logic signed [PROD_W-1:0] prod_full;
  logic signed [PROD_W-1:0] prod_bias;
  logic signed [TERM_W-1:0] term;

  assign gain_sel  = cmd.mul_l ? gl_r : gr_r;
  assign prod_full = word_r * gain_sel;
  // Adding scale minus one to negative products makes the shift truncate toward zero.
  assign prod_bias = prod_r + {{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{prod_r[PROD_W-1]}}};
  assign term      = prod_bias[PROD_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      act_r <= act;
      gl_r  <= GAIN_ONE - pan_ext;
      gr_r  <= GAIN_ONE + pan_ext;
      expire_r[cmd.slot] <= expire;
    end
    if (cmd.mul_l || cmd.mul_r) begin
      prod_r      <= prod_full;
      prod_left_r <= cmd.mul_l;
      prod_act_r  <= act_r;
    end
    if (cmd.start_voice && free_any) begin
      onset_r[free_idx]  <= in_voice_onset;
      length_r[free_idx] <= in_voice_length;
      vstart_r[free_idx] <= in_voice_start;
      pan_r[free_idx]    <= in_voice_pan;
    end
    if (cmd.tick_begin) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (prod_vld_r && prod_act_r) begin
      if (prod_left_r) begin
        acc_l_r <= acc_l_r + ACC_W'(term);
      end else begin
        acc_r_r <= acc_r_r + ACC_W'(term);
      end
    end
    if (cmd.tick_end) begin
      out_left_r   <= sat16(acc_l_r);
      out_right_r  <= sat16(acc_r_r);
      out_status_r <= STAT_SAMPLE;
    end else if (cmd.start_voice) begin
      out_left_r   <= '0;
      out_right_r  <= '0;
      out_status_r <= free_any ? STAT_VOICE_OK : STAT_VOICE_FULL;
    end else if (cmd.write_word) begin
      out_left_r   <= '0;
      out_right_r  <= '0;
      out_status_r <= STAT_WORD_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_busy_r <= '0;
      clock_r     <= '0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      prod_vld_r  <= cmd.mul_l || cmd.mul_r;
      out_valid_r <= cmd.tick_end || cmd.start_voice || cmd.write_word;
      if (cmd.start_voice && free_any) begin
        slot_busy_r[free_idx] <= 1'b1;
      end
      if (cmd.tick_end) begin
        clock_r     <= now_inc;
        slot_busy_r <= slot_busy_r & ~expire_r;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;
  assign out_status    = out_status_r;

endmodule

`default_nettype wire

[src/svsm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module svsm_checker
  import svsm_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic        [1:0]  in_mode,
  input wire logic               out_valid,
  input wire logic signed [15:0] out_left_out,
  input wire logic signed [15:0] out_right_out,
  input wire logic        [1:0]  out_status
);

  logic accept;
  assign accept = start && !busy;

  a_word_beat : assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_mode == MODE_WORD) |=> out_valid && (out_status == STAT_WORD_OK))
    else $error("word write did not give its beat on the next cycle");

  a_voice_beat : assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_mode == MODE_VOICE) |=>
      out_valid && ((out_status == STAT_VOICE_OK) || (out_status == STAT_VOICE_FULL)))
    else $error("voice start did not give its beat on the next cycle");

  a_tick_busy : assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_mode != MODE_VOICE) && (in_mode != MODE_WORD) |=> busy && !out_valid)
    else $error("tick did not hold busy while mixing");

  a_sample_end : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_SAMPLE) |-> !busy && $past(busy))
    else $error("sample beat not at the end of a mix pass");

  a_quiet_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_SAMPLE) |-> (out_left_out == 0) && (out_right_out == 0))
    else $error("non-sample beat carries nonzero audio");

endmodule

bind stereo_voice_sample_mixer svsm_checker u_svsm_checker (.*);

`default_nettype wire
